FILE: rtl/core/bsm_pkg.sv
// shared types and constants for the bank switching mapper
// no dependencies, compile first
package bsm_pkg;

  // payload widths of the request and response channels
  localparam int unsigned TYPE_W = 3;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned MAP_W  = 21;

  // configuration register widths and apb geometry
  localparam int unsigned PRG_CNT_W = 8;
  localparam int unsigned CHR_CNT_W = 6;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;

  // bank register file
  localparam int unsigned BANK_REGS  = 8;
  localparam int unsigned BANK_IDX_W = 3;
  localparam int unsigned BANK_W     = 8;

  // offsets inside a program slot and a graphics slot
  localparam int unsigned PRG_OFFS_W = 13;
  localparam int unsigned CHR_OFFS_W = 10;

  // power-on register values
  localparam logic [PRG_CNT_W-1:0] PRG_CNT_RESET = 8'd2;
  localparam logic [CHR_CNT_W-1:0] CHR_CNT_RESET = 6'd0;

  // graphics mask used when the cartridge carries graphics ram
  localparam logic [BANK_W-1:0] CHR_RAM_MASK = 8'h07;

  typedef enum logic [TYPE_W-1:0] {
    REQ_CPU_RD   = 3'd0,
    REQ_CPU_WR   = 3'd1,
    REQ_PPU_RD   = 3'd2,
    REQ_PPU_WR   = 3'd3,
    REQ_SCANLINE = 3'd4,
    REQ_IRQ_ACK  = 3'd5
  } req_type_e;

  typedef enum logic {
    REG_PRG_COUNT = 1'b0,
    REG_CHR_COUNT = 1'b1
  } reg_idx_e;

  // cpu write windows inside 8000-FFFF, taken from address bits 14:13
  typedef enum logic [1:0] {
    WIN_BANK      = 2'd0,
    WIN_MIRROR    = 2'd1,
    WIN_IRQ_LATCH = 2'd2,
    WIN_IRQ_EN    = 2'd3
  } wr_win_e;

  // top address bits of the cpu work ram window and the ppu pattern window
  localparam logic [2:0] WRAM_WIN = 3'b011;
  localparam logic [2:0] CHR_WIN  = 3'b000;

  // what the response stage needs to finish one mapped access
  typedef struct packed {
    logic                  handled;
    logic                  map_en;
    logic                  is_chr;
    logic                  use_mem;
    logic                  from_wram;
    logic                  lsb_clr;
    logic                  lsb_set;
    logic [BANK_W-1:0]     fixed_bank;
    logic [BANK_W-1:0]     mask;
    logic [PRG_OFFS_W-1:0] offs;
  } map_ctl_t;

endpackage

FILE: rtl/core/bsm_if.sv
// request and response channel interfaces of the mapper
// depends on bsm_pkg
interface bsm_req_if;
  import bsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [ADDR_W-1:0] bus_addr;
  logic [DATA_W-1:0] write_byte;

  modport source (output valid, req_type, bus_addr, write_byte, input ready);
  modport sink (input valid, req_type, bus_addr, write_byte, output ready);
endinterface

interface bsm_rsp_if;
  import bsm_pkg::*;

  logic              valid;
  logic              ready;
  logic              handled;
  logic [MAP_W-1:0]  mem_offset;
  logic              from_work_ram;
  logic [DATA_W-1:0] read_byte;
  logic              irq_pending;
  logic              mirror_horizontal;

  modport source (
    output valid, handled, mem_offset, from_work_ram, read_byte, irq_pending,
           mirror_horizontal,
    input  ready
  );
  modport sink (
    input  valid, handled, mem_offset, from_work_ram, read_byte, irq_pending,
           mirror_horizontal,
    output ready
  );
endinterface

FILE: rtl/core/bank_switch_mapper_with_scanline_irq.sv
// latency: a response is valid in the cycle after its request is accepted
// throughput: one request per cycle unless a response stalls; each request makes one pass through the
//   bank ram and work ram read port, whose registered output feeds the response register stage
// reset: asynchronous, active low; clears control state, the bank valid bits and the irq counter
//   the work ram is not cleared and needs no clearing pass, so requests are taken straight away
// depends on bsm_pkg, bsm_if and bsm_ram
module bank_switch_mapper_with_scanline_irq #(
  parameter int unsigned WORK_RAM_BYTES = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bsm_req_if.sink                     req_i,
  bsm_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsm_pkg::APB_AW-1:0]  paddr,
  input  logic [bsm_pkg::APB_DW-1:0]  pwdata,
  output logic [bsm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bsm_pkg::*;

  localparam int unsigned WramAw = $clog2(WORK_RAM_BYTES);

  // ---------------------------------------------------------------------------
  // configuration registers, word decoded on paddr bit 2
  // ---------------------------------------------------------------------------
  logic [PRG_CNT_W-1:0] prg_cnt_q;
  logic [CHR_CNT_W-1:0] chr_cnt_q;
  logic                 cfg_wr;
  reg_idx_e             cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_cnt_q <= PRG_CNT_RESET;
      chr_cnt_q <= CHR_CNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PRG_COUNT: prg_cnt_q <= pwdata[PRG_CNT_W-1:0];
        REG_CHR_COUNT: chr_cnt_q <= pwdata[CHR_CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PRG_COUNT: prdata = {{(APB_DW-PRG_CNT_W){1'b0}}, prg_cnt_q};
      REG_CHR_COUNT: prdata = {{(APB_DW-CHR_CNT_W){1'b0}}, chr_cnt_q};
    endcase
  end

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  logic              req_acc;
  logic              s1_valid_q;
  req_type_e         kind;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  logic              even;
  logic              in_wram;
  logic              in_chr;
  wr_win_e           win;

  assign req_i.ready = ~s1_valid_q | rsp_o.ready;
  assign req_acc     = req_i.valid & req_i.ready;
  assign kind        = req_type_e'(req_i.req_type);
  assign addr        = req_i.bus_addr;
  assign data        = req_i.write_byte;
  assign even        = ~addr[0];
  assign in_wram     = (addr[15:13] == WRAM_WIN);
  assign in_chr      = (addr[15:13] == CHR_WIN);
  assign win         = wr_win_e'(addr[14:13]);

  // ---------------------------------------------------------------------------
  // control state, updated at the acceptance edge so the next request sees it
  // ---------------------------------------------------------------------------
  logic [BANK_IDX_W-1:0] tgt_q, tgt_d;
  logic                  swap_q, swap_d;
  logic                  inv_q, inv_d;
  logic                  bw_q, bw_d;
  logic                  mirror_q, mirror_d;
  logic [BANK_W-1:0]     latch_q, latch_d;
  logic [BANK_W-1:0]     cnt_q, cnt_d;
  logic                  reload_q, reload_d;
  logic                  en_q, en_d;
  logic                  raised_q, raised_d;
  logic [BANK_REGS-1:0]  bank_vld_q;

  // bank register writes go to the bank ram at the current target select
  logic bank_we;
  assign bank_we = req_acc & (kind == REQ_CPU_WR) & addr[15] & (win == WIN_BANK) & ~even;

  always_comb begin
    tgt_d    = tgt_q;
    swap_d   = swap_q;
    inv_d    = inv_q;
    bw_d     = bw_q;
    mirror_d = mirror_q;
    latch_d  = latch_q;
    cnt_d    = cnt_q;
    reload_d = reload_q;
    en_d     = en_q;
    raised_d = raised_q;
    if (req_acc) begin
      unique case (kind)
        REQ_CPU_WR: begin
          if (addr[15]) begin
            unique case (win)
              WIN_BANK: begin
                // even selects the target and the modes, odd loads the bank ram
                if (even) begin
                  tgt_d  = data[BANK_IDX_W-1:0];
                  swap_d = data[6];
                  inv_d  = data[7];
                end
                bw_d = 1'b1;
              end
              WIN_MIRROR: begin
                if (even) begin
                  mirror_d = data[0];
                end
              end
              WIN_IRQ_LATCH: begin
                if (even) begin
                  latch_d = data;
                end else begin
                  reload_d = 1'b1;
                end
              end
              WIN_IRQ_EN: begin
                if (even) begin
                  en_d     = 1'b0;
                  raised_d = 1'b0;
                end else begin
                  en_d = 1'b1;
                end
              end
            endcase
          end
        end
        REQ_SCANLINE: begin
          // reload on zero or on request, else count down
          if ((cnt_q == '0) || reload_q) begin
            cnt_d    = latch_q;
            reload_d = 1'b0;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
          if ((cnt_d == '0) && en_q) begin
            raised_d = 1'b1;
          end
        end
        REQ_IRQ_ACK: begin
          raised_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q      <= '0;
      swap_q     <= 1'b0;
      inv_q      <= 1'b0;
      bw_q       <= 1'b0;
      mirror_q   <= 1'b0;
      latch_q    <= '0;
      cnt_q      <= '0;
      reload_q   <= 1'b0;
      en_q       <= 1'b0;
      raised_q   <= 1'b0;
      bank_vld_q <= '0;
    end else begin
      tgt_q    <= tgt_d;
      swap_q   <= swap_d;
      inv_q    <= inv_d;
      bw_q     <= bw_d;
      mirror_q <= mirror_d;
      latch_q  <= latch_d;
      cnt_q    <= cnt_d;
      reload_q <= reload_d;
      en_q     <= en_d;
      raised_q <= raised_d;
      // an entry never written reads as zero
      if (bank_we) begin
        bank_vld_q[tgt_q] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // mapping decision: either a fixed bank or one bank ram entry plus a tweak
  // ---------------------------------------------------------------------------
  logic [BANK_W-1:0]     prg_last;
  logic [BANK_W-1:0]     prg_last2;
  logic [BANK_W-1:0]     chr_bank_mask;
  logic [1:0]            prg_slot;
  logic [2:0]            chr_slot;
  logic [2:0]            chr_k;
  logic [BANK_IDX_W-1:0] bank_ridx;
  map_ctl_t              ctl;

  assign prg_last  = {prg_cnt_q[PRG_CNT_W-2:0], 1'b0} - 8'd1;
  assign prg_last2 = {prg_cnt_q[PRG_CNT_W-2:0], 1'b0} - 8'd2;
  assign chr_bank_mask = (chr_cnt_q == '0) ? CHR_RAM_MASK : ({chr_cnt_q[4:0], 3'b000} - 8'd1);
  assign prg_slot  = addr[14:13];
  assign chr_slot  = addr[12:10];
  // inversion swaps the 2 KB half with the 1 KB half
  assign chr_k     = chr_slot ^ {inv_q, 2'b00};

  always_comb begin
    ctl       = '0;
    bank_ridx = '0;
    ctl.offs  = addr[PRG_OFFS_W-1:0];
    unique case (kind)
      REQ_CPU_RD: begin
        if (in_wram) begin
          ctl.handled   = 1'b1;
          ctl.from_wram = 1'b1;
        end else if (addr[15]) begin
          ctl.handled = 1'b1;
          ctl.map_en  = 1'b1;
          ctl.mask    = prg_last;
          priority if (prg_slot == 2'd3) begin
            // last slot is pinned to the final bank
            ctl.fixed_bank = prg_last;
          end else if (!bw_q) begin
            // power-on layout: 0, 1, second-last
            ctl.fixed_bank = (prg_slot == 2'd2) ? prg_last2 : {6'd0, prg_slot};
          end else if (prg_slot == 2'd1) begin
            ctl.use_mem = 1'b1;
            bank_ridx   = 3'd7;
          end else if ((prg_slot == 2'd0) == !swap_q) begin
            ctl.use_mem = 1'b1;
            bank_ridx   = 3'd6;
          end else begin
            ctl.fixed_bank = prg_last2;
          end
        end
      end
      REQ_CPU_WR: begin
        ctl.handled = in_wram | addr[15];
      end
      REQ_PPU_RD, REQ_PPU_WR: begin
        if (in_chr && ((kind == REQ_PPU_RD) || (chr_cnt_q == '0))) begin
          ctl.handled = 1'b1;
          ctl.map_en  = 1'b1;
          ctl.is_chr  = 1'b1;
          ctl.mask    = chr_bank_mask;
          if (!bw_q) begin
            ctl.fixed_bank = {5'd0, chr_slot};
          end else begin
            ctl.use_mem = 1'b1;
            if (!chr_k[2]) begin
              // 2 KB banks: pair of registers 0 and 1, low bit forced
              bank_ridx   = {2'b00, chr_k[1]};
              ctl.lsb_set = chr_k[0];
              ctl.lsb_clr = ~chr_k[0];
            end else begin
              bank_ridx = chr_k - 3'd2;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  logic [BANK_W-1:0] bank_rdata;
  logic [DATA_W-1:0] wram_rdata;

  bsm_ram #(
    .WIDTH (BANK_W),
    .DEPTH (BANK_REGS)
  ) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .waddr_i (tgt_q),
    .wdata_i (data),
    .re_i    (req_acc & ctl.use_mem),
    .raddr_i (bank_ridx),
    .rdata_o (bank_rdata)
  );

  bsm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WORK_RAM_BYTES)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (req_acc & (kind == REQ_CPU_WR) & in_wram),
    .waddr_i (addr[WramAw-1:0]),
    .wdata_i (data),
    .re_i    (req_acc & ctl.from_wram),
    .raddr_i (addr[WramAw-1:0]),
    .rdata_o (wram_rdata)
  );

  // ---------------------------------------------------------------------------
  // response stage; the ram outputs only move on acceptance so they hold in a stall
  // ---------------------------------------------------------------------------
  map_ctl_t s1_ctl_q;
  logic     s1_bvld_q;
  logic     s1_irq_q;
  logic     s1_mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_acc) begin
      s1_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_ctl_q    <= ctl;
      s1_bvld_q   <= bank_vld_q[bank_ridx];
      s1_irq_q    <= raised_d;
      s1_mirror_q <= mirror_d;
    end
  end

  logic [BANK_W-1:0] bank_raw;
  logic [BANK_W-1:0] bank_mod;
  logic [BANK_W-1:0] bank_fin;

  assign bank_raw = s1_bvld_q ? bank_rdata : '0;
  assign bank_mod = (bank_raw & ~{7'd0, s1_ctl_q.lsb_clr}) | {7'd0, s1_ctl_q.lsb_set};
  assign bank_fin = s1_ctl_q.use_mem ? (bank_mod & s1_ctl_q.mask) : s1_ctl_q.fixed_bank;

  always_comb begin
    if (!s1_ctl_q.map_en) begin
      rsp_o.mem_offset = '0;
    end else if (s1_ctl_q.is_chr) begin
      rsp_o.mem_offset = {3'd0, bank_fin, s1_ctl_q.offs[CHR_OFFS_W-1:0]};
    end else begin
      rsp_o.mem_offset = {bank_fin, s1_ctl_q.offs};
    end
  end

  assign rsp_o.valid             = s1_valid_q;
  assign rsp_o.handled           = s1_ctl_q.handled;
  assign rsp_o.from_work_ram     = s1_ctl_q.from_wram;
  assign rsp_o.read_byte         = s1_ctl_q.from_wram ? wram_rdata : '0;
  assign rsp_o.irq_pending       = s1_irq_q;
  assign rsp_o.mirror_horizontal = s1_mirror_q;

endmodule

FILE: rtl/core/bsm_ram.sv
// generic single write port ram with a registered read port
// no dependencies
module bsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/bsm_checker.sv
// port level checks for the mapper, attached to the top level by bind
// depends on bsm_pkg and bank_switch_mapper_with_scanline_irq
module bsm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [bsm_pkg::TYPE_W-1:0]  in_type_i,
  input logic [bsm_pkg::ADDR_W-1:0]  in_addr_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_handled_i,
  input logic [bsm_pkg::MAP_W-1:0]   out_addr_i,
  input logic                        out_wram_i,
  input logic [bsm_pkg::DATA_W-1:0]  out_byte_i,
  input logic                        out_irq_i
);
  import bsm_pkg::*;

  logic in_acc;
  logic out_stall;
  logic irq_clear;

  assign in_acc    = in_valid_i & in_ready_i;
  assign out_stall = out_valid_i & ~out_ready_i;
  assign irq_clear = (in_type_i == REQ_IRQ_ACK) ||
                     ((in_type_i == REQ_CPU_WR) && (in_addr_i[15:13] == 3'b111) && !in_addr_i[0]);

  // every accepted request answers in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("response missing one cycle after request");

  // a response only follows a request or a held stall
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($past(in_acc) || $past(out_stall)))
    else $error("response without request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i && $stable(out_addr_i) && $stable(out_byte_i) &&
                  $stable(out_handled_i))
    else $error("stalled response changed");

  // acknowledge or disable drops the interrupt in its own response
  a_irq_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && irq_clear) |=> !out_irq_i)
    else $error("irq still pending after clear");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (!out_handled_i || out_wram_i)) |-> (out_addr_i == '0))
    else $error("mapped address set on unmapped response");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_checker u_bsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_type_i     (req_i.req_type),
  .in_addr_i     (req_i.bus_addr),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_handled_i (rsp_o.handled),
  .out_addr_i    (rsp_o.mem_offset),
  .out_wram_i    (rsp_o.from_work_ram),
  .out_byte_i    (rsp_o.read_byte),
  .out_irq_i     (rsp_o.irq_pending)
);
